[hdl/etls_pkg.sv]
// etls_pkg: constants, codes and shared types for the totient sieve block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none
package etls_pkg;

    localparam int MAX_VALUE  = 65536;
    localparam int MAX_PRIMES = 6542;

    // fixed field widths
    localparam int VAL_W = 17;
    localparam int TOT_W = 16;
    localparam int PT_W  = 13;
    localparam int ST_W  = 2;

    // derived storage widths
    localparam int AW  = $clog2(MAX_VALUE + 1);
    localparam int CW  = $clog2(MAX_PRIMES + 1);
    localparam int PAW = $clog2(MAX_PRIMES);
    localparam int PW  = 2 * AW;

    localparam logic REQ_BUILD  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NOT_BUILT = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic b_start;
        logic clr_step;
        logic i_first;
        logic i_inc;
        logic i_rd;
        logic i_eval;
        logic j_rd;
        logic j_mul;
        logic j_chk;
        logic j_inc;
        logic build_done;
        logic out_load;
        logic out_build;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_build;
        logic lim_ge2;
        logic i_at_lim;
        logic j_ge_cnt;
        logic prod_gt_lim;
        logic j_eq_spf;
    } sts_t;

endpackage
`default_nettype wire

[hdl/etls_if.sv]
// etls_req_if / etls_res_if: valid-ready channels for requests and results
// depends on etls_pkg
`timescale 1ns / 1ps
`default_nettype none
interface etls_req_if import etls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [VAL_W-1:0] query_value;

    modport source (output valid, output req_type, output query_value, input ready);
    modport sink   (input valid, input req_type, input query_value, output ready);
endinterface

interface etls_res_if import etls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOT_W-1:0] totient;
    logic             value_is_prime;
    logic [PT_W-1:0]  prime_total;
    logic [ST_W-1:0]  status;

    modport source (output valid, output totient, output value_is_prime,
                    output prime_total, output status, input ready);
    modport sink   (input valid, input totient, input value_is_prime,
                    input prime_total, input status, output ready);
endinterface
`default_nettype wire

[hdl/etls_ram.sv]
// etls_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module etls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[hdl/etls_ctrl.sv]
// etls_ctrl: sequencer for lookups and for the clear and sieve passes
// depends on etls_pkg
`timescale 1ns / 1ps
`default_nettype none
module etls_ctrl import etls_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire logic out_ready,
    output logic      out_valid,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b0000000001,
        S_LK_OUT  = 10'b0000000010,
        S_B_START = 10'b0000000100,
        S_CLEAR   = 10'b0000001000,
        S_I_RD    = 10'b0000010000,
        S_I_EVAL  = 10'b0000100000,
        S_J_RD    = 10'b0001000000,
        S_J_MUL   = 10'b0010000000,
        S_J_CHK   = 10'b0100000000,
        S_B_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = sts.req_build ? S_B_START : S_LK_OUT;
                end
            end
            S_LK_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_B_START:
            begin
                cmd.b_start = 1'b1;
                state_next  = sts.lim_ge2 ? S_CLEAR : S_B_DONE;
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.i_at_lim)
                begin
                    cmd.i_first = 1'b1;
                    state_next  = S_I_RD;
                end
                else
                begin
                    cmd.i_inc = 1'b1;
                end
            end
            S_I_RD:
            begin
                cmd.i_rd   = 1'b1;
                state_next = S_I_EVAL;
            end
            S_I_EVAL:
            begin
                cmd.i_eval = 1'b1;
                state_next = S_J_RD;
            end
            S_J_RD:
            begin
                if (sts.j_ge_cnt)
                begin
                    // no more primes to multiply by: next value
                    if (sts.i_at_lim)
                    begin
                        state_next = S_B_DONE;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_I_RD;
                    end
                end
                else
                begin
                    cmd.j_rd   = 1'b1;
                    state_next = S_J_MUL;
                end
            end
            S_J_MUL:
            begin
                cmd.j_mul  = 1'b1;
                state_next = S_J_CHK;
            end
            S_J_CHK:
            begin
                cmd.j_chk = 1'b1;
                if (sts.prod_gt_lim || sts.j_eq_spf)
                begin
                    if (sts.i_at_lim)
                    begin
                        state_next = S_B_DONE;
                    end
                    else
                    begin
                        cmd.i_inc  = 1'b1;
                        state_next = S_I_RD;
                    end
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_J_RD;
                end
            end
            S_B_DONE:
            begin
                if (out_free)
                begin
                    cmd.build_done = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_build  = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[hdl/etls_dpath.sv]
// etls_dpath: counters, multipliers, sieve memories and result register
// depends on etls_pkg and etls_ram
`timescale 1ns / 1ps
`default_nettype none
module etls_dpath import etls_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [VAL_W-1:0] cfg_wr_data,
    input  wire logic             req_type,
    input  wire logic [VAL_W-1:0] query_value,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    output logic      [TOT_W-1:0] totient,
    output logic                  value_is_prime,
    output logic      [PT_W-1:0]  prime_total,
    output logic      [ST_W-1:0]  status
);

    localparam int FW = TOT_W + AW;

    // control state
    logic [VAL_W-1:0] limit_cfg_reg;
    logic             built_reg;
    logic [AW-1:0]    blim_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;

    // working registers
    logic [VAL_W-1:0] x_reg;
    logic [AW-1:0]    lim_reg;
    logic [AW-1:0]    i_reg;
    logic [CW-1:0]    j_reg;
    logic [CW-1:0]    spf_reg;
    logic [TOT_W-1:0] phi_reg;
    logic [PW-1:0]    prod_reg;
    logic [TOT_W-1:0] phiprod_reg;

    logic [TOT_W-1:0] tot_reg;
    logic             isp_reg;
    logic [PT_W-1:0]  pt_reg;
    logic [ST_W-1:0]  st_reg;

    // memory ports
    logic             tot_we, mark_we, pl_we, rd_en;
    logic [AW-1:0]    tot_waddr, mark_waddr, rd_addr;
    logic [TOT_W-1:0] tot_wdata, tot_rdata;
    logic [CW-1:0]    mark_wdata, mark_rdata;
    logic [AW-1:0]    pl_rdata;

    logic [AW-1:0]    lim_sat;
    logic             is_new_prime;
    logic             pl_room;
    logic [AW-1:0]    factor;
    logic [FW-1:0]    phiprod_full;
    logic [PW-1:0]    prod_full;

    assign lim_sat = (32'(limit_cfg_reg) > 32'(MAX_VALUE)) ? AW'(MAX_VALUE)
                                                            : AW'(limit_cfg_reg);

    assign is_new_prime = (mark_rdata == '0);
    assign pl_room      = (32'(cnt_reg) < 32'(MAX_PRIMES));

    assign sts.req_build   = (req_type == REQ_BUILD);
    assign sts.lim_ge2     = (lim_reg >= AW'(2));
    assign sts.i_at_lim    = (i_reg == lim_reg);
    assign sts.j_ge_cnt    = (j_reg >= cnt_reg);
    assign sts.prod_gt_lim = (prod_reg > PW'(lim_reg));
    assign sts.j_eq_spf    = (j_reg == spf_reg);

    // the smallest prime factor divides i exactly when j reaches its index
    assign factor       = sts.j_eq_spf ? pl_rdata : pl_rdata - AW'(1);
    assign phiprod_full = FW'(phi_reg) * FW'(factor);
    assign prod_full    = PW'(pl_rdata) * PW'(i_reg);

    assign rd_en   = cmd.accept || cmd.i_rd;
    assign rd_addr = cmd.accept ? AW'(query_value) : i_reg;

    always_comb
    begin
        tot_we    = 1'b0;
        tot_waddr = i_reg;
        tot_wdata = TOT_W'(i_reg - AW'(1));
        if (cmd.b_start)
        begin
            tot_we    = (lim_reg != '0);
            tot_waddr = AW'(1);
            tot_wdata = TOT_W'(1);
        end
        else if (cmd.i_eval)
        begin
            tot_we = is_new_prime;
        end
        else if (cmd.j_chk)
        begin
            tot_we    = !sts.prod_gt_lim;
            tot_waddr = prod_reg[AW-1:0];
            tot_wdata = phiprod_reg;
        end
    end

    always_comb
    begin
        mark_we    = 1'b0;
        mark_waddr = i_reg;
        mark_wdata = '0;
        if (cmd.clr_step)
        begin
            mark_we = 1'b1;
        end
        else if (cmd.j_chk)
        begin
            // mark holds the smallest factor's list index plus one
            mark_we    = !sts.prod_gt_lim;
            mark_waddr = prod_reg[AW-1:0];
            mark_wdata = j_reg + CW'(1);
        end
    end

    assign pl_we = cmd.i_eval && is_new_prime && pl_room;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.b_start)
        begin
            cnt_next = '0;
        end
        else if (pl_we)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
    end

    etls_ram #(.WIDTH(TOT_W), .DEPTH(MAX_VALUE + 1)) u_tot_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (tot_rdata)
    );

    etls_ram #(.WIDTH(CW), .DEPTH(MAX_VALUE + 1)) u_mark_ram (
        .clk   (clk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (mark_rdata)
    );

    etls_ram #(.WIDTH(AW), .DEPTH(MAX_PRIMES)) u_plist_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (cnt_reg[PAW-1:0]),
        .wdata (i_reg),
        .re    (cmd.j_rd),
        .raddr (j_reg[PAW-1:0]),
        .rdata (pl_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg <= VAL_W'(MAX_VALUE);
            built_reg     <= 1'b0;
            blim_reg      <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_cfg_reg <= cfg_wr_data;
            end
            if (cmd.build_done)
            begin
                built_reg <= 1'b1;
                blim_reg  <= lim_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            x_reg   <= query_value;
            lim_reg <= lim_sat;
        end
        if (cmd.b_start || cmd.i_first)
        begin
            i_reg <= AW'(2);
        end
        else if (cmd.i_inc)
        begin
            i_reg <= i_reg + AW'(1);
        end
        if (cmd.i_eval)
        begin
            j_reg <= '0;
            if (is_new_prime)
            begin
                phi_reg <= TOT_W'(i_reg - AW'(1));
                spf_reg <= cnt_reg;
            end
            else
            begin
                phi_reg <= tot_rdata;
                spf_reg <= mark_rdata - CW'(1);
            end
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + CW'(1);
        end
        if (cmd.j_mul)
        begin
            prod_reg    <= prod_full;
            phiprod_reg <= phiprod_full[TOT_W-1:0];
        end
        if (cmd.out_load)
        begin
            tot_reg <= '0;
            isp_reg <= 1'b0;
            pt_reg  <= built_reg ? PT_W'(cnt_reg) : '0;
            st_reg  <= ST_OK;
            if (cmd.out_build)
            begin
                pt_reg <= PT_W'(cnt_reg);
            end
            else if (!built_reg)
            begin
                st_reg <= ST_NOT_BUILT;
            end
            else if (x_reg == '0 || 32'(x_reg) > 32'(blim_reg))
            begin
                st_reg <= ST_RANGE;
            end
            else
            begin
                tot_reg <= tot_rdata;
                isp_reg <= (x_reg >= VAL_W'(2)) && (mark_rdata == '0);
            end
        end
    end

    assign totient        = tot_reg;
    assign value_is_prime = isp_reg;
    assign prime_total    = pt_reg;
    assign status         = st_reg;

endmodule
`default_nettype wire

[hdl/euler_totient_linear_sieve.sv]
// euler_totient_linear_sieve: top level of the linear sieve totient table
// depends on etls_pkg, etls_if, etls_ctrl, etls_dpath, etls_ram
//
// usage
//   req is a valid/ready channel; a beat carries req_type and query_value.
//   req_type build (0) runs the sieve up to sieve_limit (saturated to the
//   table size); req_type lookup (1) returns phi(query_value) and a prime
//   flag. every request beat gives exactly one beat on res.
//   cfg_wr_en / cfg_wr_data write sieve_limit; write only while idle.
//   the new limit applies to the next build, the built table is untouched.
// sequence of work
//   lookup: both memories are read as the request is taken; the result
//   register loads from them once free. in_ready is high only in idle.
//   build: clearing the composite marks from 2 to the limit, then per value
//   a read and a classify step, a read, multiply and check per composite it
//   produces, and a closing read, multiply and check (product above limit)
//   or a lone read (list exhausted) unless its smallest factor ends the walk
// reset: rst_n restores the default limit and clears the built flag and the
//   prime count; memories are not cleared, a build clears the marks it uses
// stall
//   the result register holds a beat until res.ready; the next request is
//   taken meanwhile and its result waits until the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module euler_totient_linear_sieve import etls_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [VAL_W-1:0] cfg_wr_data,
    etls_req_if.sink              req,
    etls_res_if.source            res
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: handshakes and state walk
    etls_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (res.ready),
        .out_valid (res.valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath: counters, multipliers, memories, result payload
    etls_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_type       (req.req_type),
        .query_value    (req.query_value),
        .cmd            (cmd),
        .sts            (sts),
        .totient        (res.totient),
        .value_is_prime (res.value_is_prime),
        .prime_total    (res.prime_total),
        .status         (res.status)
    );

endmodule
`default_nettype wire

[hdl/etls_checker.sv]
// etls_checker: port-level assertions on the result channel, bound to the top
// depends on etls_pkg and euler_totient_linear_sieve
`timescale 1ns / 1ps
`default_nettype none
module etls_checker import etls_pkg::*; (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             res_valid,
    input wire logic             res_ready,
    input wire logic [TOT_W-1:0] totient,
    input wire logic             value_is_prime,
    input wire logic [PT_W-1:0]  prime_total,
    input wire logic [ST_W-1:0]  status
);

    // stalled beat keeps valid, totient and status
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(totient) && $stable(status))
        else $error("result beat changed while stalled");

    // error results carry no totient and no prime flag
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != ST_OK |-> totient == '0 && !value_is_prime)
        else $error("error result with payload");

    // nothing built means no primes counted
    a_unbuilt: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status == ST_NOT_BUILT |-> prime_total == '0)
        else $error("prime count before any build");

    // a prime is at least two, so its totient and the prime count are nonzero
    a_prime_phi: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && value_is_prime |-> totient != '0 && prime_total != '0)
        else $error("prime flag with zero totient or count");

endmodule

bind euler_totient_linear_sieve etls_checker u_etls_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .totient        (res.totient),
    .value_is_prime (res.value_is_prime),
    .prime_total    (res.prime_total),
    .status         (res.status)
);
`default_nettype wire

[dv/tb_euler_totient_linear_sieve.sv]
// tb_euler_totient_linear_sieve: self-checking bench for the linear sieve totient block
// depends on etls_pkg, etls_if and the euler_totient_linear_sieve rtl
// walks limit settings, builds the table, then checks lookups against a local sieve
`timescale 1ns / 1ps
`default_nettype none
module tb_euler_totient_linear_sieve;
    import etls_pkg::*;

    localparam int RUN_LIMIT = 4000000;

    typedef struct {
        logic             kind;
        logic [VAL_W-1:0] value;
    } sieve_req_t;

    typedef struct {
        logic [TOT_W-1:0] totient;
        logic             is_prime;
        logic [PT_W-1:0]  prime_total;
        logic [ST_W-1:0]  status;
    } sieve_res_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [VAL_W-1:0] cfg_wr_data;

    etls_req_if req_ch ();
    etls_res_if res_ch ();

    euler_totient_linear_sieve dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .res         (res_ch)
    );

    always #1 clk = ~clk;

    // requests waiting for the driver, results waiting for the dut
    sieve_req_t pending_reqs[$];
    sieve_res_t expected_res[$];
    int         mismatches = 0;
    int         cycles     = 0;

    // local copy of the block state
    logic [VAL_W-1:0] limit_reg;
    bit               marked[0:MAX_VALUE];
    logic [TOT_W-1:0] phi_tab[0:MAX_VALUE];
    int               primes[0:MAX_PRIMES-1];
    int               n_primes;
    bit               built;
    int               built_lim;

    // linear sieve up to the saturated limit
    function automatic void sieve_build();
        int lim;
        int k;
        int q;
        lim = (limit_reg > MAX_VALUE) ? MAX_VALUE : int'(limit_reg);
        for (int v = 0; v <= MAX_VALUE; v++) marked[v] = 1'b0;
        n_primes = 0;
        if (lim >= 1) phi_tab[1] = TOT_W'(1);
        for (int v = 2; v <= lim; v++)
        begin
            if (!marked[v])
            begin
                if (n_primes < MAX_PRIMES)
                begin
                    primes[n_primes] = v;
                    n_primes++;
                end
                phi_tab[v] = TOT_W'(v - 1);
            end
            for (k = 0; k < n_primes; k++)
            begin
                q = primes[k];
                if (longint'(q) * v > lim) break;
                marked[q * v] = 1'b1;
                if (v % q == 0)
                begin
                    phi_tab[q * v] = TOT_W'(int'(phi_tab[v]) * q);
                    break;
                end
                phi_tab[q * v] = TOT_W'(int'(phi_tab[v]) * (q - 1));
            end
        end
        built_lim = lim;
        built     = 1'b1;
    endfunction

    function automatic sieve_res_t sieve_answer(sieve_req_t r);
        sieve_res_t a;
        a = '{totient: '0, is_prime: 1'b0, prime_total: '0, status: ST_OK};
        if (r.kind == REQ_BUILD)
            sieve_build();
        else if (!built)
            a.status = ST_NOT_BUILT;
        else if (r.value == 0 || int'(r.value) > built_lim)
            a.status = ST_RANGE;
        else
        begin
            a.totient  = phi_tab[r.value];
            a.is_prime = (r.value >= 2) && !marked[r.value];
        end
        a.prime_total = built ? PT_W'(n_primes) : '0;
        return a;
    endfunction

    // driver: bursts of beats with random gaps between them
    sieve_req_t cur_req;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.req_type    <= REQ_LOOKUP;
            req_ch.query_value <= '0;
        end
        else
        begin
            // a beat goes through at this edge
            if (req_ch.valid && req_ch.ready)
            begin
                cur_req.kind  = req_ch.req_type;
                cur_req.value = req_ch.query_value;
                expected_res.insert(expected_res.size(), sieve_answer(cur_req));
            end
            // hold a beat that the dut has not taken yet
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    cur_req = pending_reqs.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= cur_req.kind;
                    req_ch.query_value <= cur_req.value;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each result beat and drives ready from a randomly redrawn stall mode
    int stall_mode = 0;
    int mode_age   = 0;
    sieve_res_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            cycles++;
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_res.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: tot/prime/pt/st %0d/%0b/%0d/%0d",
                                 res_ch.totient, res_ch.value_is_prime,
                                 res_ch.prime_total, res_ch.status);
                end
                else
                begin
                    want = expected_res.pop_front();
                    if (res_ch.totient !== want.totient
                        || res_ch.value_is_prime !== want.is_prime
                        || res_ch.prime_total !== want.prime_total
                        || res_ch.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %0d/%0b/%0d/%0d got %0d/%0b/%0d/%0d",
                                     want.totient, want.is_prime, want.prime_total, want.status,
                                     res_ch.totient, res_ch.value_is_prime,
                                     res_ch.prime_total, res_ch.status);
                    end
                end
            end
            if (mode_age == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_age   = 50;
            end
            mode_age--;
            case (stall_mode)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= 1'($urandom_range(0, 1));
                default: res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (cycles > RUN_LIMIT)
        begin
            $display("tb_euler_totient_linear_sieve: done, errors");
            $finish;
        end
    end

    // stimulus side view of the table limit
    int gen_lim   = -1;
    int gen_count = 0;

    task automatic push_req(logic kind, int v);
        sieve_req_t r;
        r.kind  = kind;
        r.value = VAL_W'(v);
        pending_reqs.insert(pending_reqs.size(), r);
        gen_count++;
    endtask

    task automatic push_build(int cfg);
        push_req(REQ_BUILD, $urandom());
        gen_lim = (cfg > MAX_VALUE) ? MAX_VALUE : cfg;
    endtask

    // mostly values inside the built range, some at its edges and beyond
    task automatic push_lookup();
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 60 && gen_lim >= 1)
            v = $urandom_range(1, gen_lim);
        else if (pick < 70)
            v = 0;
        else if (pick < 85)
            v = (gen_lim < 2 ? 0 : gen_lim - 2) + $urandom_range(0, 4);
        else
            v = $urandom_range(0, (1 << VAL_W) - 1);
        push_req(REQ_LOOKUP, v);
    endtask

    // only write the limit once nothing is in flight
    task automatic write_limit(int v);
        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= VAL_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        limit_reg = VAL_W'(v);
    endtask

    int phase_lims[8] = '{0, 1, 2, 100, 131071, 997, 30, 4096};

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        limit_reg   = VAL_W'(MAX_VALUE);
        built       = 1'b0;
        built_lim   = 0;
        n_primes    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // lookups before any build report not built
        push_req(REQ_LOOKUP, 1);
        push_req(REQ_LOOKUP, 0);
        push_req(REQ_LOOKUP, (1 << VAL_W) - 1);

        for (int ph = 0; ph < 8; ph++)
        begin
            write_limit(phase_lims[ph]);
            // new limit must not disturb the old table
            repeat (3) push_lookup();
            push_build(phase_lims[ph]);
            // directed corners of each setting
            push_req(REQ_LOOKUP, 1);
            push_req(REQ_LOOKUP, 0);
            push_req(REQ_LOOKUP, 2);
            push_req(REQ_LOOKUP, gen_lim);
            push_req(REQ_LOOKUP, gen_lim + 1);
            if (gen_lim == MAX_VALUE)
            begin
                push_req(REQ_LOOKUP, 65521);
                push_req(REQ_LOOKUP, 65535);
                push_req(REQ_LOOKUP, (1 << VAL_W) - 1);
            end
            for (int n = 0; n < 170; n++)
            begin
                // occasional rebuild on cheap settings
                if (gen_lim <= 5000 && $urandom_range(0, 99) < 3)
                    push_build(phase_lims[ph]);
                else
                    push_lookup();
            end
        end

        while (pending_reqs.size() > 0 || req_ch.valid || expected_res.size() > 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_euler_totient_linear_sieve: done, clean");
        else
            $display("tb_euler_totient_linear_sieve: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
